FILE: src/mbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared constants, register map and helper types for the matte border
// detector.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int DIM_CFG_W  = 12;
  localparam int SAMPLE_W   = 8;
  localparam int TOL_W      = 10;
  localparam int DIST_W     = 10;

  localparam logic [DIM_CFG_W-1:0] RST_FRAME_WIDTH  = 12'd720;
  localparam logic [DIM_CFG_W-1:0] RST_FRAME_HEIGHT = 12'd576;
  localparam logic [SAMPLE_W-1:0]  RST_MATTE_LUMA   = 8'd16;
  localparam logic [SAMPLE_W-1:0]  RST_MATTE_CB     = 8'd128;
  localparam logic [SAMPLE_W-1:0]  RST_MATTE_CR     = 8'd128;
  localparam logic [TOL_W-1:0]     RST_TOLERANCE    = 10'd6;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_MATTE_LUMA   = 3'd2,
    REG_MATTE_CB     = 3'd3,
    REG_MATTE_CR     = 3'd4,
    REG_TOLERANCE    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic first_col;
    logic first_row;
    logic row_end;
    logic last_row;
  } pix_flags_t;

  function automatic logic [DIST_W-1:0] absdiff(input logic [SAMPLE_W-1:0] a,
                                                input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return DIST_W'(d);
  endfunction

endpackage

FILE: src/mbd_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_scan
// Raster position counters and per-pixel matte distance at the input beat.
// ----------------------------------------------------------------------------
module mbd_scan #(
  parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mbd_pkg::SAMPLE_W-1:0]         in_luma,
  input  logic [mbd_pkg::SAMPLE_W-1:0]         in_chroma_b,
  input  logic [mbd_pkg::SAMPLE_W-1:0]         in_chroma_r,
  input  logic [mbd_pkg::SAMPLE_W-1:0]         matte_luma,
  input  logic [mbd_pkg::SAMPLE_W-1:0]         matte_cb,
  input  logic [mbd_pkg::SAMPLE_W-1:0]         matte_cr,
  input  logic [$clog2(MAX_WIDTH):0]           width,
  input  logic [$clog2(MAX_HEIGHT):0]          height,
  input  logic                                 s1_free,
  output logic                                 acc,
  output logic [$clog2(MAX_WIDTH)-1:0]         col_addr,
  output logic [$clog2(MAX_HEIGHT)-1:0]        row_idx,
  output mbd_pkg::pix_flags_t                  flags,
  output logic [mbd_pkg::DIST_W-1:0]           pix_dist
);

  localparam int WA_W = $clog2(MAX_WIDTH);
  localparam int HA_W = $clog2(MAX_HEIGHT);
  localparam int WD_W = WA_W + 1;
  localparam int HD_W = HA_W + 1;

  logic [WA_W-1:0] col_pos_r, col_pos_nxt;
  logic [HA_W-1:0] row_pos_r, row_pos_nxt;
  logic            row_end, last_row;

  assign in_ready = s1_free;
  assign acc      = in_valid && s1_free;

  assign row_end  = (WD_W'(col_pos_r) + WD_W'(1)) >= width;
  assign last_row = (HD_W'(row_pos_r) + HD_W'(1)) >= height;

  assign pix_dist = mbd_pkg::absdiff(in_luma, matte_luma)
                  + mbd_pkg::absdiff(in_chroma_b, matte_cb)
                  + mbd_pkg::absdiff(in_chroma_r, matte_cr);

  assign col_addr        = col_pos_r;
  assign row_idx         = row_pos_r;
  assign flags.first_col = (col_pos_r == '0);
  assign flags.first_row = (row_pos_r == '0);
  assign flags.row_end   = row_end;
  assign flags.last_row  = last_row;

  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (acc) begin
      if (row_end) begin
        col_pos_nxt = '0;
        row_pos_nxt = last_row ? '0 : row_pos_r + HA_W'(1);
      end else begin
        col_pos_nxt = col_pos_r + WA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

endmodule

FILE: src/mbd_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_accum
// Column sum memory (read, add, write back) with last-write forwarding,
// and the running row sum.
// ----------------------------------------------------------------------------
module mbd_accum #(
  parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      acc,
  input  logic [$clog2(MAX_WIDTH)-1:0]              col_addr,
  input  logic [$clog2(MAX_HEIGHT)-1:0]             row_idx,
  input  mbd_pkg::pix_flags_t                       flags,
  input  logic [mbd_pkg::DIST_W-1:0]                pix_dist,
  input  logic                                      s2_free,
  output logic                                      s1_free,
  output logic                                      s1_go,
  output logic [$clog2(MAX_WIDTH)-1:0]              s1_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]             s1_row,
  output mbd_pkg::pix_flags_t                       s1_flags,
  output logic [$clog2(765*MAX_HEIGHT+1)-1:0]       col_sum,
  output logic [$clog2(765*MAX_WIDTH+1)-1:0]        row_sum
);

  localparam int WA_W = $clog2(MAX_WIDTH);
  localparam int HA_W = $clog2(MAX_HEIGHT);
  localparam int CS_W = $clog2(765*MAX_HEIGHT+1);
  localparam int RS_W = $clog2(765*MAX_WIDTH+1);

  logic [CS_W-1:0] mem [MAX_WIDTH];

  logic                       s1_v_r;
  logic [WA_W-1:0]            s1_col_r;
  logic [HA_W-1:0]            s1_row_r;
  mbd_pkg::pix_flags_t        s1_flags_r;
  logic [mbd_pkg::DIST_W-1:0] s1_dist_r;
  logic [CS_W-1:0]            rd_data_r;
  logic                       lw_v_r;
  logic [WA_W-1:0]            lw_addr_r;
  logic [CS_W-1:0]            lw_data_r;
  logic [RS_W-1:0]            row_sum_r;
  logic [CS_W-1:0]            col_base;

  assign s1_go   = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s1_go;

  // write of the previous beat may land on the entry just read
  always_comb begin
    if (s1_flags_r.first_row) begin
      col_base = '0;
    end else if (lw_v_r && (lw_addr_r == s1_col_r)) begin
      col_base = lw_data_r;
    end else begin
      col_base = rd_data_r;
    end
  end

  assign col_sum  = col_base + CS_W'(s1_dist_r);
  assign row_sum  = s1_flags_r.first_col ? RS_W'(s1_dist_r) : row_sum_r + RS_W'(s1_dist_r);
  assign s1_col   = s1_col_r;
  assign s1_row   = s1_row_r;
  assign s1_flags = s1_flags_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data_r <= mem[col_addr];
    end
    if (s1_go) begin
      mem[s1_col_r] <= col_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r   <= col_addr;
      s1_row_r   <= row_idx;
      s1_flags_r <= flags;
      s1_dist_r  <= pix_dist;
    end
    if (s1_go) begin
      lw_addr_r <= s1_col_r;
      lw_data_r <= col_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      lw_v_r    <= 1'b0;
      row_sum_r <= '0;
    end else begin
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        lw_v_r    <= 1'b1;
        row_sum_r <= row_sum;
      end
    end
  end

  a_take_only_when_leaving: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && s1_v_r) |-> s2_free)
    else $error("new beat overwrote a stalled accumulate stage");

  a_forward_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> (lw_v_r && (lw_addr_r == $past(s1_col_r))))
    else $error("forwarding register missed a column write");

endmodule

FILE: src/mbd_edges.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_edges
// Content tests against tolerance thresholds, first/last content tracking
// and the result register.
// ----------------------------------------------------------------------------
module mbd_edges #(
  parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  take,
  input  logic [$clog2(MAX_WIDTH)-1:0]          s1_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]         s1_row,
  input  mbd_pkg::pix_flags_t                   s1_flags,
  input  logic [$clog2(765*MAX_HEIGHT+1)-1:0]   col_sum,
  input  logic [$clog2(765*MAX_WIDTH+1)-1:0]    row_sum,
  input  logic [$clog2(MAX_WIDTH):0]            width,
  input  logic [$clog2(MAX_HEIGHT):0]           height,
  input  logic [mbd_pkg::TOL_W-1:0]             tolerance,
  output logic                                  s2_free,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [$clog2(MAX_WIDTH):0]            out_left_edge,
  output logic [$clog2(MAX_HEIGHT):0]           out_top_edge,
  output logic [$clog2(MAX_WIDTH)-1:0]          out_right_edge,
  output logic [$clog2(MAX_HEIGHT)-1:0]         out_bottom_edge
);

  localparam int WA_W = $clog2(MAX_WIDTH);
  localparam int HA_W = $clog2(MAX_HEIGHT);
  localparam int WD_W = WA_W + 1;
  localparam int HD_W = HA_W + 1;
  localparam int CS_W = $clog2(765*MAX_HEIGHT+1);
  localparam int RS_W = $clog2(765*MAX_WIDTH+1);
  localparam int TW_W = mbd_pkg::TOL_W + 1 + WD_W;
  localparam int TH_W = mbd_pkg::TOL_W + 1 + HD_W;

  logic [TW_W-1:0]     thr_row_r;
  logic [TH_W-1:0]     thr_col_r;

  logic                s2_v_r;
  logic [WA_W-1:0]     s2_col_r;
  logic [HA_W-1:0]     s2_row_r;
  mbd_pkg::pix_flags_t s2_flags_r;
  logic [CS_W-1:0]     s2_csum_r;
  logic [RS_W-1:0]     s2_rsum_r;

  logic [HD_W-1:0]     top_r, top_nxt, top_base;
  logic [HA_W-1:0]     bottom_r, bottom_nxt, bottom_base;
  logic [WD_W-1:0]     left_r, left_nxt, left_base;
  logic [WA_W-1:0]     right_r, right_nxt, right_base;

  logic                out_valid_r;
  logic [WD_W-1:0]     out_left_r;
  logic [HD_W-1:0]     out_top_r;
  logic [WA_W-1:0]     out_right_r;
  logic [HA_W-1:0]     out_bottom_r;

  logic                frame_first, col_hit, row_hit, s2_emit, out_free, s2_go;

  assign frame_first = s2_flags_r.first_col && s2_flags_r.first_row;
  assign s2_emit     = s2_flags_r.row_end && s2_flags_r.last_row;
  assign out_free    = !out_valid_r || out_ready;
  assign s2_go       = s2_v_r && (!s2_emit || out_free);
  assign s2_free     = !s2_v_r || s2_go;

  assign col_hit = s2_flags_r.last_row && (TH_W'(s2_csum_r) >= thr_col_r);
  assign row_hit = s2_flags_r.row_end && (TW_W'(s2_rsum_r) >= thr_row_r);

  always_comb begin
    top_base    = frame_first ? height : top_r;
    left_base   = frame_first ? width  : left_r;
    bottom_base = frame_first ? '0     : bottom_r;
    right_base  = frame_first ? '0     : right_r;

    left_nxt  = left_base;
    right_nxt = right_base;
    if (col_hit) begin
      right_nxt = s2_col_r;
      if (WD_W'(s2_col_r) < left_base) begin
        left_nxt = WD_W'(s2_col_r);
      end
    end

    top_nxt    = top_base;
    bottom_nxt = bottom_base;
    if (row_hit) begin
      bottom_nxt = s2_row_r;
      if (HD_W'(s2_row_r) < top_base) begin
        top_nxt = HD_W'(s2_row_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    thr_row_r <= (TW_W'(tolerance) + TW_W'(1)) * TW_W'(width);
    thr_col_r <= (TH_W'(tolerance) + TH_W'(1)) * TH_W'(height);
    if (take) begin
      s2_col_r   <= s1_col;
      s2_row_r   <= s1_row;
      s2_flags_r <= s1_flags;
      s2_csum_r  <= col_sum;
      s2_rsum_r  <= row_sum;
    end
    if (s2_go) begin
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
    end
    if (s2_go && s2_emit) begin
      out_left_r   <= left_nxt;
      out_top_r    <= top_nxt;
      out_right_r  <= right_nxt;
      out_bottom_r <= bottom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        s2_v_r <= 1'b1;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_go && s2_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_edge   = out_left_r;
  assign out_top_edge    = out_top_r;
  assign out_right_edge  = out_right_r;
  assign out_bottom_edge = out_bottom_r;

  a_emit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && s2_emit) |=> out_valid_r)
    else $error("frame end did not load the result register");

  a_edges_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_right_r == '0 || out_left_r <= WD_W'(out_right_r)) &&
                     (out_bottom_r == '0 || out_top_r <= HD_W'(out_bottom_r))))
    else $error("first content edge lies past last content edge");

endmodule

FILE: src/matte_border_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matte_border_detect
// Finds the content rectangle inside a solid matte in a raster pixel stream.
//
//   port group   dir   flow control      beat contents
//   in_*         in    valid / ready     one pixel: luma, Cb, Cr
//   out_*        out   valid / ready     left, top, right, bottom edges
//   cfg_*        in    write enable      register index, write data
//
// One pixel per cycle sustained; the column sum memory does one read and
// one write per cycle, its single write port sets that figure.
// A frame's last pixel passes the accumulate and edge stages before its
// result loads the output register. Reset is synchronous; the column memory
// needs no clearing since row 0 of each frame overwrites it. A held result
// only stalls input once a further frame-end pixel reaches the last stage.
// ----------------------------------------------------------------------------
module matte_border_detect #(
  parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mbd_pkg::SAMPLE_W-1:0]       in_luma,
  input  logic [mbd_pkg::SAMPLE_W-1:0]       in_chroma_b,
  input  logic [mbd_pkg::SAMPLE_W-1:0]       in_chroma_r,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [$clog2(MAX_WIDTH):0]         out_left_edge,
  output logic [$clog2(MAX_HEIGHT):0]        out_top_edge,
  output logic [$clog2(MAX_WIDTH)-1:0]       out_right_edge,
  output logic [$clog2(MAX_HEIGHT)-1:0]      out_bottom_edge,
  input  logic                               cfg_we,
  input  logic [mbd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int WA_W = $clog2(MAX_WIDTH);
  localparam int HA_W = $clog2(MAX_HEIGHT);
  localparam int WD_W = WA_W + 1;
  localparam int HD_W = HA_W + 1;
  localparam int CS_W = $clog2(765*MAX_HEIGHT+1);
  localparam int RS_W = $clog2(765*MAX_WIDTH+1);

  logic [mbd_pkg::DIM_CFG_W-1:0] frame_width_r, frame_height_r;
  logic [mbd_pkg::SAMPLE_W-1:0]  matte_luma_r, matte_cb_r, matte_cr_r;
  logic [mbd_pkg::TOL_W-1:0]     tolerance_r;

  logic [WD_W-1:0]               width;
  logic [HD_W-1:0]               height;

  logic                          acc, s1_free, s1_go, s2_free;
  logic [WA_W-1:0]               col_addr, s1_col;
  logic [HA_W-1:0]               row_idx, s1_row;
  mbd_pkg::pix_flags_t           flags, s1_flags;
  logic [mbd_pkg::DIST_W-1:0]    pix_dist;
  logic [CS_W-1:0]               col_sum;
  logic [RS_W-1:0]               row_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= mbd_pkg::RST_FRAME_WIDTH;
      frame_height_r <= mbd_pkg::RST_FRAME_HEIGHT;
      matte_luma_r   <= mbd_pkg::RST_MATTE_LUMA;
      matte_cb_r     <= mbd_pkg::RST_MATTE_CB;
      matte_cr_r     <= mbd_pkg::RST_MATTE_CR;
      tolerance_r    <= mbd_pkg::RST_TOLERANCE;
    end else if (cfg_we) begin
      case (mbd_pkg::cfg_reg_t'(cfg_addr))
        mbd_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        mbd_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        mbd_pkg::REG_MATTE_LUMA:   matte_luma_r   <= cfg_wdata[mbd_pkg::SAMPLE_W-1:0];
        mbd_pkg::REG_MATTE_CB:     matte_cb_r     <= cfg_wdata[mbd_pkg::SAMPLE_W-1:0];
        mbd_pkg::REG_MATTE_CR:     matte_cr_r     <= cfg_wdata[mbd_pkg::SAMPLE_W-1:0];
        mbd_pkg::REG_TOLERANCE:    tolerance_r    <= cfg_wdata[mbd_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (frame_width_r == '0) begin
      width = WD_W'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      width = WD_W'(MAX_WIDTH);
    end else begin
      width = WD_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      height = HD_W'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      height = HD_W'(MAX_HEIGHT);
    end else begin
      height = HD_W'(frame_height_r);
    end
  end

  mbd_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_luma     (in_luma),
    .in_chroma_b (in_chroma_b),
    .in_chroma_r (in_chroma_r),
    .matte_luma  (matte_luma_r),
    .matte_cb    (matte_cb_r),
    .matte_cr    (matte_cr_r),
    .width       (width),
    .height      (height),
    .s1_free     (s1_free),
    .acc         (acc),
    .col_addr    (col_addr),
    .row_idx     (row_idx),
    .flags       (flags),
    .pix_dist    (pix_dist)
  );

  mbd_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .col_addr (col_addr),
    .row_idx  (row_idx),
    .flags    (flags),
    .pix_dist (pix_dist),
    .s2_free  (s2_free),
    .s1_free  (s1_free),
    .s1_go    (s1_go),
    .s1_col   (s1_col),
    .s1_row   (s1_row),
    .s1_flags (s1_flags),
    .col_sum  (col_sum),
    .row_sum  (row_sum)
  );

  mbd_edges #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_edges (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (s1_go),
    .s1_col          (s1_col),
    .s1_row          (s1_row),
    .s1_flags        (s1_flags),
    .col_sum         (col_sum),
    .row_sum         (row_sum),
    .width           (width),
    .height          (height),
    .tolerance       (tolerance_r),
    .s2_free         (s2_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_edge   (out_left_edge),
    .out_top_edge    (out_top_edge),
    .out_right_edge  (out_right_edge),
    .out_bottom_edge (out_bottom_edge)
  );

endmodule

FILE: test/matte_border_detect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matte_border_detect_tb
// Self-checking bench for the matte border detector. A short scripted run
// covers the distance extremes, exact threshold hits, zero frame sizes
// and sizes changed mid-frame. Runs at oversized width and at
// maximum height, cut short inside the frame, lead into random frames with
// a matte border around a content box. Each edge beat is checked against
// the script's edges or an in-bench scan model, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module matte_border_detect_tb;
  import mbd_pkg::*;

  localparam int LEFT_W          = $clog2(DEF_MAX_WIDTH) + 1;
  localparam int TOP_W           = $clog2(DEF_MAX_HEIGHT) + 1;
  localparam int RIGHT_W         = $clog2(DEF_MAX_WIDTH);
  localparam int BOTTOM_W        = $clog2(DEF_MAX_HEIGHT);
  localparam int RANDOM_PIXELS   = 1700;
  localparam int LONG_RUN_PIXELS = 100;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 800000;
  localparam int MAX_REPORTS     = 100;

  typedef struct packed {
    logic [LEFT_W-1:0]   left;
    logic [TOP_W-1:0]    top;
    logic [RIGHT_W-1:0]  right;
    logic [BOTTOM_W-1:0] bottom;
  } border_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_CHK} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic [SAMPLE_W-1:0]   y;
    logic [SAMPLE_W-1:0]   cb;
    logic [SAMPLE_W-1:0]   cr;
    border_t               want;
  } stim_row_t;

  localparam border_t NO_BORDER = '0;
  localparam int SCRIPT_LEN = 48;

  // ROW_CHK rows carry the edges expected at that frame's last pixel
  stim_row_t directed_script [SCRIPT_LEN] = '{
    '{ROW_CFG, REG_FRAME_WIDTH,  12'd1,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_FRAME_HEIGHT, 12'd1,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_TOLERANCE,    12'd0,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CHK, REG_FRAME_WIDTH,  12'd0,    8'd16,  8'd128, 8'd128,
      '{12'd1, 12'd1, 11'd0, 11'd0}},
    '{ROW_CHK, REG_FRAME_WIDTH,  12'd0,    8'd17,  8'd128, 8'd128,
      '{12'd0, 12'd0, 11'd0, 11'd0}},
    '{ROW_CFG, REG_MATTE_LUMA,   12'd0,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_MATTE_CB,     12'd0,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_MATTE_CR,     12'd0,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_TOLERANCE,    12'd764,  8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CHK, REG_FRAME_WIDTH,  12'd0,    8'd255, 8'd255, 8'd255,
      '{12'd0, 12'd0, 11'd0, 11'd0}},
    '{ROW_CHK, REG_FRAME_WIDTH,  12'd0,    8'd254, 8'd255, 8'd255,
      '{12'd1, 12'd1, 11'd0, 11'd0}},
    '{ROW_CFG, REG_TOLERANCE,    12'd765,  8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CHK, REG_FRAME_WIDTH,  12'd0,    8'd255, 8'd255, 8'd255,
      '{12'd1, 12'd1, 11'd0, 11'd0}},
    '{ROW_CFG, REG_TOLERANCE,    12'hFFF,  8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CHK, REG_FRAME_WIDTH,  12'd0,    8'd255, 8'd255, 8'd255,
      '{12'd1, 12'd1, 11'd0, 11'd0}},
    '{ROW_CFG, REG_MATTE_LUMA,   12'hFFF,  8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_MATTE_CB,     12'h3FF,  8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_MATTE_CR,     12'h0FF,  8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_TOLERANCE,    12'd764,  8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CHK, REG_FRAME_WIDTH,  12'd0,    8'd0,   8'd0,   8'd0,
      '{12'd0, 12'd0, 11'd0, 11'd0}},
    '{ROW_CFG, REG_FRAME_WIDTH,  12'd0,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_FRAME_HEIGHT, 12'd0,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CHK, REG_FRAME_WIDTH,  12'd0,    8'd0,   8'd0,   8'd0,
      '{12'd0, 12'd0, 11'd0, 11'd0}},
    '{ROW_CHK, REG_FRAME_WIDTH,  12'd0,    8'd255, 8'd255, 8'd255,
      '{12'd1, 12'd1, 11'd0, 11'd0}},
    '{ROW_CFG, REG_FRAME_WIDTH,  12'd2,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_FRAME_HEIGHT, 12'd2,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_TOLERANCE,    12'd0,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd255, 8'd255, 8'd255, NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd0,   8'd255, 8'd255, NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'd255, 8'd255, 8'd255, NO_BORDER},
    '{ROW_CHK, REG_FRAME_WIDTH,  12'd0,    8'd255, 8'd255, 8'd255,
      '{12'd1, 12'd0, 11'd1, 11'd0}},
    // width shrinks in the middle of row 0
    '{ROW_CFG, REG_FRAME_WIDTH,  12'd4,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_CFG, REG_FRAME_HEIGHT, 12'd2,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'h00,  8'hFF,  8'h80,  NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'hFF,  8'h00,  8'h7F,  NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'h5A,  8'hA5,  8'h01,  NO_BORDER},
    '{ROW_CFG, REG_FRAME_WIDTH,  12'd2,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'hFE,  8'hFD,  8'hFC,  NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'h01,  8'h02,  8'h03,  NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'h80,  8'h80,  8'h80,  NO_BORDER},
    // height shrinks below the current row
    '{ROW_CFG, REG_FRAME_HEIGHT, 12'd4,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'h33,  8'hCC,  8'hF0,  NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'h0F,  8'hF0,  8'h55,  NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'hAA,  8'h55,  8'h00,  NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'hFF,  8'hFF,  8'h00,  NO_BORDER},
    '{ROW_CFG, REG_FRAME_HEIGHT, 12'd1,    8'd0,   8'd0,   8'd0,   NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'h11,  8'h22,  8'h44,  NO_BORDER},
    '{ROW_PIX, REG_FRAME_WIDTH,  12'd0,    8'hEE,  8'hDD,  8'hBB,  NO_BORDER}
  };

  logic                    clk;
  logic                    rst_n       = 1'b0;
  logic                    in_valid    = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_W-1:0]     in_luma     = '0;
  logic [SAMPLE_W-1:0]     in_chroma_b = '0;
  logic [SAMPLE_W-1:0]     in_chroma_r = '0;
  logic                    out_valid;
  logic                    out_ready   = 1'b0;
  logic [LEFT_W-1:0]       out_left_edge;
  logic [TOP_W-1:0]        out_top_edge;
  logic [RIGHT_W-1:0]      out_right_edge;
  logic [BOTTOM_W-1:0]     out_bottom_edge;
  logic                    cfg_we      = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr    = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata   = '0;

  matte_border_detect u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_luma         (in_luma),
    .in_chroma_b     (in_chroma_b),
    .in_chroma_r     (in_chroma_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_edge   (out_left_edge),
    .out_top_edge    (out_top_edge),
    .out_right_edge  (out_right_edge),
    .out_bottom_edge (out_bottom_edge),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // scan model state
  int unsigned reg_width  = RST_FRAME_WIDTH;
  int unsigned reg_height = RST_FRAME_HEIGHT;
  int unsigned matte_y    = RST_MATTE_LUMA;
  int unsigned matte_b    = RST_MATTE_CB;
  int unsigned matte_r    = RST_MATTE_CR;
  int unsigned tol_reg    = RST_TOLERANCE;
  int unsigned scan_col   = 0;
  int unsigned scan_row   = 0;
  int unsigned line_sum   = 0;
  int unsigned column_acc [DEF_MAX_WIDTH];
  int unsigned top_hit    = 0;
  int unsigned bottom_hit = 0;
  int unsigned left_hit   = 0;
  int unsigned right_hit  = 0;

  border_t     pending_borders [$];
  border_t     front_border;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned burst_left  = 0;
  int unsigned pixels_sent = 0;

  function automatic int unsigned effective_dim(input int unsigned v,
                                                input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned chan_dist(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit line_has_content(input int unsigned sum, input int unsigned len);
    return longint'(sum) >= (longint'(tol_reg) + 1) * longint'(len);
  endfunction

  function automatic logic [SAMPLE_W-1:0] near_value(input int unsigned base,
                                                     input int unsigned amp);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * amp)) - int'(amp);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return SAMPLE_W'(v);
  endfunction

  task automatic advance_border_scan(input logic [SAMPLE_W-1:0] y,
                                     input logic [SAMPLE_W-1:0] cb,
                                     input logic [SAMPLE_W-1:0] cr,
                                     output bit produced, output border_t res);
    int unsigned w, h, d, c;
    bit          row_end, last_row;
    w        = effective_dim(reg_width, DEF_MAX_WIDTH);
    h        = effective_dim(reg_height, DEF_MAX_HEIGHT);
    d        = chan_dist(y, matte_y) + chan_dist(cb, matte_b) + chan_dist(cr, matte_r);
    c        = scan_col % DEF_MAX_WIDTH;
    row_end  = scan_col + 1 >= w;
    last_row = scan_row + 1 >= h;
    produced = 1'b0;
    res      = '0;
    if (scan_col == 0 && scan_row == 0) begin
      top_hit    = h;
      left_hit   = w;
      bottom_hit = 0;
      right_hit  = 0;
    end
    line_sum      = (scan_col == 0) ? d : line_sum + d;
    column_acc[c] = (scan_row == 0) ? d : column_acc[c] + d;
    if (last_row && line_has_content(column_acc[c], h)) begin
      right_hit = c;
      if (c < left_hit) left_hit = c;
    end
    if (row_end) begin
      if (line_has_content(line_sum, w)) begin
        bottom_hit = scan_row;
        if (scan_row < top_hit) top_hit = scan_row;
      end
      scan_col = 0;
      if (last_row) begin
        res.left   = LEFT_W'(left_hit);
        res.top    = TOP_W'(top_hit);
        res.right  = RIGHT_W'(right_hit);
        res.bottom = BOTTOM_W'(bottom_hit);
        produced   = 1'b1;
        scan_row   = 0;
      end else begin
        scan_row++;
      end
    end else begin
      scan_col++;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  reg_width  = val;
      REG_FRAME_HEIGHT: reg_height = val;
      REG_MATTE_LUMA:   matte_y    = val[SAMPLE_W-1:0];
      REG_MATTE_CB:     matte_b    = val[SAMPLE_W-1:0];
      REG_MATTE_CR:     matte_r    = val[SAMPLE_W-1:0];
      REG_TOLERANCE:    tol_reg    = val[TOL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // called and returns at a falling edge
  task automatic send_pixel(input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] cb,
                            input logic [SAMPLE_W-1:0] cr, input bit typed,
                            input border_t typed_res);
    int unsigned gap;
    bit          produced;
    border_t     res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_luma     <= y;
    in_chroma_b <= cb;
    in_chroma_r <= cr;
    do @(posedge clk); while (!in_ready);
    advance_border_scan(y, cb, cr, produced, res);
    if (typed) pending_borders.push_back(typed_res);
    else if (produced) pending_borders.push_back(res);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_borders.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_phase(input logic [CFG_DATA_W-1:0] w_val,
                           input logic [CFG_DATA_W-1:0] h_val);
    int unsigned pick;
    logic [CFG_DATA_W-1:0] tol_val;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       tol_val = '0;
      1:       tol_val = CFG_DATA_W'($urandom_range(764, 1023));
      2:       tol_val = CFG_DATA_W'($urandom_range(0, 4095));
      default: tol_val = CFG_DATA_W'($urandom_range(0, 40));
    endcase
    write_reg(REG_FRAME_WIDTH, w_val);
    write_reg(REG_FRAME_HEIGHT, h_val);
    write_reg(REG_MATTE_LUMA, CFG_DATA_W'($urandom_range(0, 4095)));
    write_reg(REG_MATTE_CB, CFG_DATA_W'($urandom_range(0, 4095)));
    write_reg(REG_MATTE_CR, CFG_DATA_W'($urandom_range(0, 4095)));
    write_reg(REG_TOLERANCE, tol_val);
  endtask

  // matte border around a content box, or all content or all matte; stops at frame end or after max_pix
  task automatic send_frame(input int unsigned max_pix);
    int unsigned w, h, x0, x1, y0, y1, style, amp, n;
    bit          in_box;
    logic [SAMPLE_W-1:0] y, cb, cr;
    w     = effective_dim(reg_width, DEF_MAX_WIDTH);
    h     = effective_dim(reg_height, DEF_MAX_HEIGHT);
    x0    = $urandom_range(0, w - 1);
    x1    = $urandom_range(x0, w - 1);
    y0    = $urandom_range(0, h - 1);
    y1    = $urandom_range(y0, h - 1);
    style = $urandom_range(0, 9);
    amp   = $urandom_range(0, 4);
    n     = 0;
    do begin
      in_box = scan_col >= x0 && scan_col <= x1 && scan_row >= y0 && scan_row <= y1;
      if (style == 7 || (style < 7 && in_box)) begin
        y  = SAMPLE_W'($urandom_range(0, 255));
        cb = SAMPLE_W'($urandom_range(0, 255));
        cr = SAMPLE_W'($urandom_range(0, 255));
      end else begin
        y  = near_value(matte_y, amp);
        cb = near_value(matte_b, amp);
        cr = near_value(matte_r, amp);
      end
      send_pixel(y, cb, cr, 1'b0, NO_BORDER);
      n++;
    end while (!(scan_col == 0 && scan_row == 0) && n < max_pix);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_borders.size() == 0) begin
        report_mismatch("beat with nothing pending, left_edge", out_left_edge, 0);
      end else begin
        front_border = pending_borders.pop_front();
        if (out_left_edge !== front_border.left)
          report_mismatch("left_edge", out_left_edge, front_border.left);
        if (out_top_edge !== front_border.top)
          report_mismatch("top_edge", out_top_edge, front_border.top);
        if (out_right_edge !== front_border.right)
          report_mismatch("right_edge", out_right_edge, front_border.right);
        if (out_bottom_edge !== front_border.bottom)
          report_mismatch("bottom_edge", out_bottom_edge, front_border.bottom);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL matte_border_detect");
      $finish;
    end
  end

  initial begin : ready_pattern
    int unsigned stall_mode, span;
    forever begin
      stall_mode = $urandom_range(0, 3);
      span       = (stall_mode == 2) ? $urandom_range(1, 16) : $urandom_range(1, 40);
      repeat (span) begin
        case (stall_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= 1'b0;
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned cur_w, rand_end;
    logic [CFG_DATA_W-1:0] w_val, h_val;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_script[i]) begin
      case (directed_script[i].kind)
        ROW_CFG: begin
          drain_results();
          write_reg(directed_script[i].reg_idx, directed_script[i].value);
        end
        ROW_PIX: send_pixel(directed_script[i].y, directed_script[i].cb,
                            directed_script[i].cr, 1'b0, NO_BORDER);
        default: send_pixel(directed_script[i].y, directed_script[i].cb,
                            directed_script[i].cr, 1'b1, directed_script[i].want);
      endcase
    end

    // oversized width and maximum height, cut short inside the frame
    drain_results();
    set_phase(12'hFFF, 12'd1);
    send_frame(LONG_RUN_PIXELS);
    drain_results();
    set_phase(12'd1, 12'd2048);
    send_frame(LONG_RUN_PIXELS);

    rand_end = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < rand_end) begin
      drain_results();
      case ($urandom_range(0, 19))
        0:       w_val = '0;
        1:       w_val = CFG_DATA_W'($urandom_range(9, 40));
        default: w_val = CFG_DATA_W'($urandom_range(1, 8));
      endcase
      // no widening below row 0: those columns were never cleared this frame
      cur_w = effective_dim(reg_width, DEF_MAX_WIDTH);
      if (scan_row != 0 && effective_dim(w_val, DEF_MAX_WIDTH) > cur_w)
        w_val = CFG_DATA_W'($urandom_range(1, cur_w));
      case ($urandom_range(0, 19))
        0:       h_val = '0;
        1:       h_val = CFG_DATA_W'($urandom_range(9, 24));
        default: h_val = CFG_DATA_W'($urandom_range(1, 6));
      endcase
      set_phase(w_val, h_val);
      repeat ($urandom_range(1, 4)) send_frame(32'hFFFF_FFFF);
      if ($urandom_range(0, 4) == 0) send_frame($urandom_range(1, 6));
    end

    drain_results();
    if (mismatches == 0) begin
      $display("PASS matte_border_detect");
    end else begin
      $display("FAIL matte_border_detect");
    end
    $finish;
  end

endmodule
